// File: sv/b64enc_pkg.sv
package b64enc_pkg;

    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int GROUP_LEN  = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;   // '='

    typedef enum logic [1:0] {
        ACT_DATA    = 2'd0,
        ACT_FINISH  = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_BUDGET   = 2'd0,
        REG_BUFFER_CAPACITY = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_0;
        logic [CHAR_W-1:0]  char_1;
        logic [CHAR_W-1:0]  char_2;
        logic [CHAR_W-1:0]  char_3;
        logic               group_valid;
        logic [2:0]         store_count;
        logic [COUNT_W-1:0] write_offset;
        logic               limit_reached;
        logic [COUNT_W-1:0] needed_total;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] output_budget;
        logic [COUNT_W-1:0] buffer_capacity;
    } cfg_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] r;
        begin
            if (v < 6'd26)
            begin
                r = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                r = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                r = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                r = 8'h2B;
            end
            else
            begin
                r = 8'h2F;
            end
            return r;
        end
    endfunction

endpackage

// File: sv/b64enc_core.sv
module b64enc_core
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [7:0]         pend0_reg, pend0_next;
    logic [7:0]         pend1_reg, pend1_next;
    logic [1:0]         count_reg, count_next;
    logic [COUNT_W-1:0] needed_reg, needed_next;
    logic [COUNT_W-1:0] stored_reg, stored_next;
    logic               limit_reg, limit_next;

    logic               is_data;
    logic               is_finish;
    logic               is_restart;
    logic               make_group;
    logic               pad_one;
    logic [7:0]         b_sel;
    logic [7:0]         c_sel;
    logic [COUNT_W:0]   needed_plus;
    logic               over_budget;
    logic               emit;
    logic [COUNT_W-1:0] avail;
    logic [2:0]         take;
    logic [CHAR_W-1:0]  g0, g1, g2, g3;

    always_comb
    begin
        is_data    = 1'b0;
        is_finish  = 1'b0;
        is_restart = 1'b0;
        case (item.action)
            ACT_DATA:    is_data    = 1'b1;
            ACT_FINISH:  is_finish  = 1'b1;
            ACT_RESTART: is_restart = 1'b1;
            default:     ;
        endcase
    end

    always_comb
    begin
        make_group = !limit_reg &&
                     ((is_data && count_reg == 2'd2) || (is_finish && count_reg != 2'd0));
        pad_one    = is_finish && count_reg == 2'd1;
        b_sel      = pad_one ? 8'd0 : pend1_reg;
        c_sel      = is_data ? item.byte_value : 8'd0;

        g0 = b64_char(pend0_reg[7:2]);
        g1 = b64_char({pend0_reg[1:0], b_sel[7:4]});
        g2 = pad_one   ? PAD_CHAR : b64_char({b_sel[3:0], c_sel[7:6]});
        g3 = is_finish ? PAD_CHAR : b64_char(c_sel[5:0]);

        needed_plus = {1'b0, needed_reg} + (COUNT_W+1)'(GROUP_LEN);
        over_budget = (cfg.output_budget != '0) &&
                      (needed_plus > {1'b0, cfg.output_budget});
        emit        = make_group && !over_budget;

        avail = (stored_reg < cfg.buffer_capacity) ? (cfg.buffer_capacity - stored_reg) : '0;
        take  = (avail < COUNT_W'(GROUP_LEN)) ? avail[2:0] : 3'(GROUP_LEN);
    end

    always_comb
    begin
        pend0_next  = pend0_reg;
        pend1_next  = pend1_reg;
        count_next  = count_reg;
        needed_next = needed_reg;
        stored_next = stored_reg;
        limit_next  = limit_reg;
        if (is_restart)
        begin
            pend0_next  = '0;
            pend1_next  = '0;
            count_next  = '0;
            needed_next = '0;
            stored_next = '0;
            limit_next  = 1'b0;
        end
        else
        begin
            if (is_data && !limit_reg && count_reg < 2'd2)
            begin
                if (count_reg[0])
                begin
                    pend1_next = item.byte_value;
                end
                else
                begin
                    pend0_next = item.byte_value;
                end
                count_next = count_reg + 2'd1;
            end
            if (make_group)
            begin
                count_next = '0;
                if (over_budget)
                begin
                    limit_next = 1'b1;
                end
                else
                begin
                    // saturate the running total
                    needed_next = needed_plus[COUNT_W] ? '1 : needed_plus[COUNT_W-1:0];
                    stored_next = stored_reg + COUNT_W'(take);
                end
            end
        end
    end

    always_comb
    begin
        result.char_0        = emit ? g0 : '0;
        result.char_1        = emit ? g1 : '0;
        result.char_2        = emit ? g2 : '0;
        result.char_3        = emit ? g3 : '0;
        result.group_valid   = emit;
        result.store_count   = emit ? take : '0;
        result.write_offset  = emit ? stored_reg : stored_next;
        result.limit_reached = limit_next;
        result.needed_total  = needed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg  <= '0;
            pend1_reg  <= '0;
            count_reg  <= '0;
            needed_reg <= '0;
            stored_reg <= '0;
            limit_reg  <= 1'b0;
        end
        else if (fire)
        begin
            pend0_reg  <= pend0_next;
            pend1_reg  <= pend1_next;
            count_reg  <= count_next;
            needed_reg <= needed_next;
            stored_reg <= stored_next;
            limit_reg  <= limit_next;
        end
    end

endmodule

// File: sv/base64_encoder_with_output_budget.sv
// Channel  Direction  Handshake               Transaction
// src      in         src_valid / src_stall   one in_item_t: action, byte_value
// dst      out        dst_valid / dst_stall   one out_item_t per src item
// cfg      in         cfg_valid / cfg_ready   register index and 32-bit data
//
// Two register stages: input register, then result register.
// One item per cycle sustained while dst_stall is low; the encoder state updates as the item moves into
// the result register. cfg_ready is always high.
// rst_n (async, active low) clears encoder state, config registers and valids.
// A stalled result holds the pipeline; src_stall rises only when both stages are full.
module base64_encoder_with_output_budget
    import b64enc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  in_item_t             src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output out_item_t            dst_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;
    logic      fire;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !dst_stall;
    assign src_stall = in_valid_reg && !advance;
    assign fire      = in_valid_reg && advance;
    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OUTPUT_BUDGET:   cfg_reg.output_budget   <= cfg_data;
                REG_BUFFER_CAPACITY: cfg_reg.buffer_capacity <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!src_stall)
            begin
                in_valid_reg <= src_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_item_reg <= src_item;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    b64enc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// File: sim/tb_base64_encoder_with_output_budget.sv
module tb_base64_encoder_with_output_budget;
    import b64enc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         WATCHDOG_MAX  = 2000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         MAX_REPORTED  = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    in_item_t             src_item = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    out_item_t            dst_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;

    base64_encoder_with_output_budget u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Encoder shadow state
    string        b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [7:0]   held_byte [2];
    logic [1:0]   held_cnt;
    logic [31:0]  total_needed;
    logic [31:0]  total_stored;
    logic         over_budget;
    logic [31:0]  cfg_budget;
    logic [31:0]  cfg_capacity;

    out_item_t    result_q [$];
    out_item_t    oldest_result;
    int           mismatch_cnt = 0;
    int           result_cnt = 0;
    int           src_idle_pct = 0;
    int           dst_idle_pct = 0;
    bit           hold_request = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    function automatic out_item_t encode_item(input logic [1:0] act, input logic [7:0] v);
        out_item_t  r;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] grp [4];
        logic       has_group;
        logic [32:0] next_needed;
        logic [31:0] avail;
        logic [31:0] take;
        r = '0;
        has_group = 1'b0;
        a = held_byte[0];
        b = held_byte[1];
        grp[0] = sextet_char(a[7:2]);
        case (act)
            ACT_RESTART:
            begin
                held_byte[0] = '0;
                held_byte[1] = '0;
                held_cnt = '0;
                total_needed = '0;
                total_stored = '0;
                over_budget = 1'b0;
            end
            ACT_DATA:
            begin
                if (!over_budget)
                begin
                    if (held_cnt < 2'd2)
                    begin
                        held_byte[held_cnt[0]] = v;
                        held_cnt = held_cnt + 2'd1;
                    end
                    else
                    begin
                        grp[1] = sextet_char({a[1:0], b[7:4]});
                        grp[2] = sextet_char({b[3:0], v[7:6]});
                        grp[3] = sextet_char(v[5:0]);
                        held_cnt = '0;
                        has_group = 1'b1;
                    end
                end
            end
            ACT_FINISH:
            begin
                if (!over_budget && held_cnt != 2'd0)
                begin
                    if (held_cnt == 2'd1)
                    begin
                        grp[1] = sextet_char({a[1:0], 4'b0000});
                        grp[2] = PAD_CHAR;
                    end
                    else
                    begin
                        grp[1] = sextet_char({a[1:0], b[7:4]});
                        grp[2] = sextet_char({b[3:0], 2'b00});
                    end
                    grp[3] = PAD_CHAR;
                    held_cnt = '0;
                    has_group = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (has_group)
        begin
            next_needed = {1'b0, total_needed} + 33'd4;
            if (cfg_budget != 32'd0 && next_needed > {1'b0, cfg_budget})
            begin
                over_budget = 1'b1;
                has_group = 1'b0;
            end
            else
            begin
                total_needed = next_needed[32] ? 32'hFFFF_FFFF : next_needed[31:0];
                avail = (total_stored < cfg_capacity) ? cfg_capacity - total_stored : 32'd0;
                take = (avail < 32'd4) ? avail : 32'd4;
                r.char_0 = grp[0];
                r.char_1 = grp[1];
                r.char_2 = grp[2];
                r.char_3 = grp[3];
                r.group_valid = 1'b1;
                r.store_count = take[2:0];
                r.write_offset = total_stored;
                total_stored = total_stored + take;
            end
        end
        if (!has_group)
            r.write_offset = total_stored;
        r.limit_reached = over_budget;
        r.needed_total = total_needed;
        return r;
    endfunction

    // Offers one transaction; the expected group is worked out once it is taken.
    task automatic issue_action(input logic [1:0] act, input logic [7:0] value);
        in_item_t it;
        it.action = act;
        it.byte_value = value;
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        result_q.push_back(encode_item(act, value));
    endtask

    task automatic program_encoder(input logic [31:0] budget, input logic [31:0] capacity);
        src_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_OUTPUT_BUDGET;
        cfg_data <= budget;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_budget = budget;
        cfg_index <= REG_BUFFER_CAPACITY;
        cfg_data <= capacity;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_capacity = capacity;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_budget();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd4 * $urandom_range(1, 40);
            3: return $urandom_range(1, 200);
            4: return $urandom;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] pick_capacity();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 300);
            3: return $urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    // Mostly data runs closed by finish; restart is favored once the budget trips.
    task automatic run_random_stream(input int n_useful);
        int          useful;
        int unsigned r;
        logic [1:0]  act;
        logic [7:0]  value;
        useful = 0;
        while (useful < n_useful)
        begin
            r = $urandom_range(99);
            value = 8'($urandom);
            if ($urandom_range(9) == 0)
                value = $urandom_range(1) ? 8'hFF : 8'h00;
            if (over_budget && r < 30)
                act = ACT_RESTART;
            else if (r < 80)
                act = ACT_DATA;
            else if (r < 93)
                act = ACT_FINISH;
            else if (r < 96)
                act = ACT_RESTART;
            else
                act = ACT_UNUSED;
            // skip the count for transactions that leave the encoder untouched
            if (!(act == ACT_UNUSED
                  || (over_budget && act != ACT_RESTART)
                  || (act == ACT_FINISH && held_cnt == 2'd0)))
                useful++;
            issue_action(act, value);
        end
    endtask

    task automatic test_alphabet_and_padding();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        // reset register values: unlimited budget, zero buffer capacity
        issue_action(ACT_DATA, 8'h4D);
        issue_action(ACT_DATA, 8'h61);
        issue_action(ACT_DATA, 8'h6E);
        issue_action(ACT_DATA, 8'hFB);
        issue_action(ACT_DATA, 8'hFF);
        issue_action(ACT_DATA, 8'h00);
        issue_action(ACT_FINISH, 8'hFF);
        issue_action(ACT_DATA, 8'h4D);
        issue_action(ACT_FINISH, 8'h00);
        issue_action(ACT_DATA, 8'h4D);
        issue_action(ACT_DATA, 8'h61);
        issue_action(ACT_FINISH, 8'h00);
        issue_action(ACT_UNUSED, 8'hAA);
    endtask

    task automatic test_budget_and_buffer();
        program_encoder(32'd8, 32'd6);
        issue_action(ACT_DATA, 8'h4D);
        issue_action(ACT_DATA, 8'h61);
        issue_action(ACT_DATA, 8'h6E);
        issue_action(ACT_DATA, 8'h00);
        issue_action(ACT_DATA, 8'h00);
        issue_action(ACT_DATA, 8'h00);
        issue_action(ACT_DATA, 8'hFF);
        issue_action(ACT_FINISH, 8'h00);    // over budget through finish
        issue_action(ACT_DATA, 8'h01);
        issue_action(ACT_FINISH, 8'h00);
        issue_action(ACT_RESTART, 8'h00);
        issue_action(ACT_DATA, 8'h10);
        issue_action(ACT_FINISH, 8'h00);
        program_encoder(32'd5, 32'd0);
        issue_action(ACT_RESTART, 8'h00);
        for (int i = 0; i < 6; i++)
            issue_action(ACT_DATA, 8'(8'h80 + i));
        issue_action(ACT_RESTART, 8'h00);
    endtask

    task automatic test_sender_idle();
        program_encoder(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        src_idle_pct = 22;
        dst_idle_pct = 47;
        run_random_stream(100);
    endtask

    task automatic test_receiver_idle();
        program_encoder(pick_budget(), pick_capacity());
        src_idle_pct = 47;
        dst_idle_pct = 22;
        run_random_stream(100);
    endtask

    task automatic test_full_rate();
        program_encoder(pick_budget(), pick_capacity());
        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random_stream(100);
    endtask

    task automatic test_output_backpressure();
        program_encoder(32'd0, $urandom_range(0, 100));
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_request = 1'b1;
        run_random_stream(40);
    endtask

    // Receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            dst_stall <= 1'b1;
        end
        else
        begin
            dst_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTED)
                $display("result %0d %s: expected 0x%08h, got 0x%08h",
                         result_cnt, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dst_valid === 1'b1 && !dst_stall)
        begin
            if (result_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTED)
                    $display("result %0d arrived with nothing expected", result_cnt);
            end
            else
            begin
                oldest_result = result_q.pop_front();
                check_field("char_0", 32'(dst_item.char_0), 32'(oldest_result.char_0));
                check_field("char_1", 32'(dst_item.char_1), 32'(oldest_result.char_1));
                check_field("char_2", 32'(dst_item.char_2), 32'(oldest_result.char_2));
                check_field("char_3", 32'(dst_item.char_3), 32'(oldest_result.char_3));
                check_field("group_valid", 32'(dst_item.group_valid),
                            32'(oldest_result.group_valid));
                check_field("store_count", 32'(dst_item.store_count),
                            32'(oldest_result.store_count));
                check_field("write_offset", dst_item.write_offset,
                            oldest_result.write_offset);
                check_field("limit_reached", 32'(dst_item.limit_reached),
                            32'(oldest_result.limit_reached));
                check_field("needed_total", dst_item.needed_total,
                            oldest_result.needed_total);
            end
            result_cnt++;
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        held_byte[0] = '0;
        held_byte[1] = '0;
        held_cnt = '0;
        total_needed = '0;
        total_stored = '0;
        over_budget = 1'b0;
        cfg_budget = '0;
        cfg_capacity = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alphabet_and_padding();
        test_budget_and_buffer();
        test_sender_idle();
        test_receiver_idle();
        test_full_rate();
        test_output_backpressure();

        src_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
